[rtl/lud_pkg.sv]
// Shared constants, types and fixed-point helpers for the 3x3 LU factorization unit.
package lud_pkg;

	localparam int DW      = 32;           // element width
	localparam int FW      = 16;           // fraction bits
	localparam int QW      = DW + FW;      // scaled dividend width
	localparam int DIV_LAT = QW + 1;       // divider pipeline depth
	localparam int PW      = 2 * DW;       // full product width

	typedef logic signed [DW-1:0] elem_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [PW:0]   wide_t;

	typedef struct packed {
		elem_t a11, a12, a13;
		elem_t a21, a22, a23;
		elem_t a31, a32, a33;
	} mat_t;

	typedef struct packed {
		elem_t u11, u12, u13;
		elem_t u22, u23, r33;
		elem_t l21, l31;
		logic  zp;
	} mid_t;

	localparam elem_t ELEM_MAX = elem_t'({1'b0, {(DW-1){1'b1}}});
	localparam elem_t ELEM_MIN = elem_t'({1'b1, {(DW-1){1'b0}}});

	// Clamp a widened value to the element range.
	function automatic elem_t sat_elem(input wide_t v);
		elem_t r;
		if (v > wide_t'(ELEM_MAX)) begin
			r = ELEM_MAX;
		end else if (v < wide_t'(ELEM_MIN)) begin
			r = ELEM_MIN;
		end else begin
			r = v[DW-1:0];
		end
		return r;
	endfunction

	// x - (p >>> FW), saturated.
	function automatic elem_t sub_prod(input elem_t x, input prod_t p);
		wide_t xw;
		wide_t pw;
		prod_t ps;
		ps = p >>> FW;
		xw = {{(PW-DW+1){x[DW-1]}}, x};
		pw = {ps[PW-1], ps};
		return sat_elem(xw - pw);
	endfunction

endpackage

[rtl/lud_mat_if.sv]
// Input channel: one 3x3 matrix per transaction.
interface lud_mat_if;
	import lud_pkg::*;
	logic  valid;
	logic  ready;
	elem_t a11, a12, a13;
	elem_t a21, a22, a23;
	elem_t a31, a32, a33;

	modport source (output valid, a11, a12, a13, a21, a22, a23, a31, a32, a33, input ready);
	modport sink (input valid, a11, a12, a13, a21, a22, a23, a31, a32, a33, output ready);
endinterface

[rtl/lud_fac_if.sv]
// Output channel: LU factors of one matrix per transaction.
interface lud_fac_if;
	import lud_pkg::*;
	logic  valid;
	logic  ready;
	elem_t u11, u12, u13, u22, u23, u33;
	elem_t l21, l31, l32;
	logic  zero_pivot;

	modport source (output valid, u11, u12, u13, u22, u23, u33, l21, l31, l32, zero_pivot,
		input ready);
	modport sink (input valid, u11, u12, u13, u22, u23, u33, l21, l31, l32, zero_pivot,
		output ready);
endinterface

[rtl/lud_div.sv]
// Pipelined restoring divider: sat((num << FW) / den), zero when den is zero.
module lud_div
	import lud_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  elem_t num,
	input  elem_t den,
	output elem_t quo
);

	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] acc_s [QW+1];
	logic [DW-1:0] dmag_s [QW+1];
	logic          neg_s [QW+1];
	logic          dz_s  [QW+1];

	logic [DW-1:0] nmag, dmag;
	logic [QW-1:0] q;

	assign nmag = num[DW-1] ? (~num + 1'b1) : num;
	assign dmag = den[DW-1] ? (~den + 1'b1) : den;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			acc_s[0]  <= {nmag, {FW{1'b0}}};
			dmag_s[0] <= dmag;
			neg_s[0]  <= num[DW-1] ^ den[DW-1];
			dz_s[0]   <= (den == '0);
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] sh, diff;
		logic        ge;
		assign sh   = {rem_s[k], acc_s[k][QW-1]};
		assign ge   = sh >= {1'b0, dmag_s[k]};
		assign diff = sh - {1'b0, dmag_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
				acc_s[k+1]  <= {acc_s[k][QW-2:0], ge};
				dmag_s[k+1] <= dmag_s[k];
				neg_s[k+1]  <= neg_s[k];
				dz_s[k+1]   <= dz_s[k];
			end
		end
	end

	assign q = acc_s[QW];

	always_comb begin
		if (dz_s[QW]) begin
			quo = '0;
		end else if (neg_s[QW]) begin
			// magnitude above 2^(DW-1) cannot be represented as a negative value
			if (q > QW'({1'b1, {(DW-1){1'b0}}})) begin
				quo = ELEM_MIN;
			end else begin
				quo = elem_t'(~q[DW-1:0] + 1'b1);
			end
		end else if (q > QW'(ELEM_MAX)) begin
			quo = ELEM_MAX;
		end else begin
			quo = q[DW-1:0];
		end
	end

endmodule

[rtl/lu_decompose_3x3_unit.sv]
// Doolittle LU factorization of a 3x3 signed Q16.16 matrix, no pivoting.
// A new matrix may enter every cycle while the output is not stalled; one factor
// set leaves per matrix, in order. The pipe holds two bit-per-stage dividers in
// series: first l21 and l31 (a21/a11, a31/a11, in parallel), then l32
// (a32'/u22). Between them one stage forms the four products l21*a12, l21*a13,
// l31*a12, l31*a13 and one stage subtracts and saturates; after the second
// divider one stage forms l32*u23 and the last stage, the output register,
// gives u33. The whole pipe advances together; it holds while the output
// transaction is not taken, and bubbles flow through. Products are truncated by
// an arithmetic shift, quotients toward zero, and every kept value saturates to
// 32 bits. A zero pivot (a11 or u22) raises zero_pivot and forces the dependent
// multipliers to zero.
module lu_decompose_3x3_unit
	import lud_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lud_mat_if.sink    mat,
	lud_fac_if.source  fac
);

	logic en;
	mat_t mat_in;

	// phase A: first-pivot dividers with matching delay line
	mat_t  a_pipe_s [DIV_LAT];
	logic  a_vld_s  [DIV_LAT];
	elem_t l21_d, l31_d;

	// products
	mat_t  m_s1;
	elem_t l21_s1, l31_s1;
	prod_t p2a_s1, p2b_s1, p3a_s1, p3b_s1;
	logic  v_s1;

	// subtract and saturate
	mid_t  mid_s2;
	elem_t r32_s2;
	logic  v_s2;

	// phase D: second-pivot divider with delay line
	mid_t  mid_zp;
	mid_t  d_pipe_s [DIV_LAT];
	logic  d_vld_s  [DIV_LAT];
	elem_t l32_d;

	// last product
	mid_t  mid_s3;
	elem_t l32_s3;
	prod_t p33_s3;
	logic  v_s3;

	// output register
	logic  out_vld_q;
	elem_t u22_q, u23_q;

	// whole pipe moves unless a finished result is stuck at the output
	assign en = !out_vld_q || fac.ready;
	assign mat.ready = en;

	assign mat_in = '{a11: mat.a11, a12: mat.a12, a13: mat.a13,
	                  a21: mat.a21, a22: mat.a22, a23: mat.a23,
	                  a31: mat.a31, a32: mat.a32, a33: mat.a33};

	lud_div u_div21 (.clk(clk), .en(en), .num(mat.a21), .den(mat.a11), .quo(l21_d));
	lud_div u_div31 (.clk(clk), .en(en), .num(mat.a31), .den(mat.a11), .quo(l31_d));

	always_ff @(posedge clk) begin
		if (en) begin
			a_pipe_s[0] <= mat_in;
			for (int k = 1; k < DIV_LAT; k++) begin
				a_pipe_s[k] <= a_pipe_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) begin
				a_vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			a_vld_s[0] <= mat.valid;
			for (int k = 1; k < DIV_LAT; k++) begin
				a_vld_s[k] <= a_vld_s[k-1];
			end
		end
	end

	// stage 1: first-elimination products
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= a_pipe_s[DIV_LAT-1];
			l21_s1 <= l21_d;
			l31_s1 <= l31_d;
			p2a_s1 <= l21_d * a_pipe_s[DIV_LAT-1].a12;
			p2b_s1 <= l21_d * a_pipe_s[DIV_LAT-1].a13;
			p3a_s1 <= l31_d * a_pipe_s[DIV_LAT-1].a12;
			p3b_s1 <= l31_d * a_pipe_s[DIV_LAT-1].a13;
		end
	end

	// stage 2: reduced rows 2 and 3
	always_ff @(posedge clk) begin
		if (en) begin
			mid_s2.u11 <= m_s1.a11;
			mid_s2.u12 <= m_s1.a12;
			mid_s2.u13 <= m_s1.a13;
			mid_s2.u22 <= sub_prod(m_s1.a22, p2a_s1);
			mid_s2.u23 <= sub_prod(m_s1.a23, p2b_s1);
			mid_s2.r33 <= sub_prod(m_s1.a33, p3b_s1);
			mid_s2.l21 <= l21_s1;
			mid_s2.l31 <= l31_s1;
			mid_s2.zp  <= (m_s1.a11 == '0);
			r32_s2     <= sub_prod(m_s1.a32, p3a_s1);
		end
	end

	lud_div u_div32 (.clk(clk), .en(en), .num(r32_s2), .den(mid_s2.u22), .quo(l32_d));

	// fold the second-pivot check into the flag before the delay line
	always_comb begin
		mid_zp    = mid_s2;
		mid_zp.zp = mid_s2.zp || (mid_s2.u22 == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_pipe_s[0] <= mid_zp;
			for (int k = 1; k < DIV_LAT; k++) begin
				d_pipe_s[k] <= d_pipe_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_vld_q <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) begin
				d_vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= a_vld_s[DIV_LAT-1];
			v_s2 <= v_s1;
			d_vld_s[0] <= v_s2;
			for (int k = 1; k < DIV_LAT; k++) begin
				d_vld_s[k] <= d_vld_s[k-1];
			end
			v_s3 <= d_vld_s[DIV_LAT-1];
			out_vld_q <= v_s3;
		end
	end

	// stage 3: second-elimination product
	always_ff @(posedge clk) begin
		if (en) begin
			mid_s3 <= d_pipe_s[DIV_LAT-1];
			l32_s3 <= l32_d;
			p33_s3 <= l32_d * d_pipe_s[DIV_LAT-1].u23;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			fac.u11 <= mid_s3.u11;
			fac.u12 <= mid_s3.u12;
			fac.u13 <= mid_s3.u13;
			u22_q   <= mid_s3.u22;
			u23_q   <= mid_s3.u23;
			fac.u33 <= sub_prod(mid_s3.r33, p33_s3);
			fac.l21 <= mid_s3.l21;
			fac.l31 <= mid_s3.l31;
			fac.l32 <= l32_s3;
			fac.zero_pivot <= mid_s3.zp;
		end
	end

	assign fac.u22   = u22_q;
	assign fac.u23   = u23_q;
	assign fac.valid = out_vld_q;

endmodule
